FILE: rtl/core/world_to_screen_projection_defines.svh
// Assertion macros shared by the projection RTL.
// Depends on a clk and an rst signal in the module that uses them.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define WSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wsp: check failed");
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsp: check failed");
`else
`define WSP_ASSERT(lbl, prop)
`define WSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/wsp_pkg.sv
// Shared types and constants of the world-to-screen projection.
// No dependencies.
package wsp_pkg;

  // Quotient magnitude is capped at 2^RatioCapBits.
  localparam int RatioCapBits = 46;
  // Width of the dividend (|clip| shifted by FRAC_BITS); clip width is this minus FRAC_BITS.
  localparam int ClipWideBits = 67;
  localparam int NearScale    = 100000;
  // Largest clip magnitude that can be scaled by NearScale without saturation.
  localparam int NearLimit    = 21474;

  localparam logic signed [31:0] Sat32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Sat32Min = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_ROW0_XY     = 3'd0,
    REG_ROW0_ZT     = 3'd1,
    REG_ROW1_XY     = 3'd2,
    REG_ROW1_ZT     = 3'd3,
    REG_ROW3_XY     = 3'd4,
    REG_ROW3_ZT     = 3'd5,
    REG_VP_SIZE     = 3'd6,
    REG_VP_ORIGIN   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic cap_x;
    logic cap_y;
  } flags_t;

  typedef struct packed {
    logic               on;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
  } side_t;

endpackage

FILE: rtl/core/world_to_screen_projection.sv
// Top level of the world-to-screen projection pipeline.
// Depends on wsp_pkg, wsp_clip, wsp_prep, wsp_div, wsp_view and the defines header.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   point   | in_valid, in_ready, point_x/y/z          | in
//   screen  | out_valid, out_ready, screen_x/y, on_scr | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One point enters per cycle unless the output stalls; stages are 2 clip,
// 1 setup, 46 divider stages at one quotient bit each, 2 viewport.
// The whole pipeline advances together: it holds whenever the output
// register holds a beat that is not taken, so no beat is dropped or repeated.
// rst clears valid bits and all config registers; cfg_ready is always high.
`include "world_to_screen_projection_defines.svh"
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               on_screen,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int CW = wsp_pkg::ClipWideBits - FRAC_BITS;
  localparam int NW = wsp_pkg::ClipWideBits;

  logic [63:0] row0_xy, row0_zt, row1_xy, row1_zt, row3_xy, row3_zt;
  logic [31:0] viewport_size, viewport_origin;

  logic               adv;
  logic signed [31:0] mat [3][4];

  logic                 clip_vld;
  logic signed [CW-1:0] clip [3];

  logic            prep_vld;
  logic [NW-1:0]   n_x, n_y;
  logic [CW-1:0]   w;
  wsp_pkg::flags_t prep_flg, div_flg;
  wsp_pkg::side_t  prep_side, div_side;

  logic                            div_vld;
  logic [wsp_pkg::RatioCapBits:0]  mag_x, mag_y;

  // Advance every stage together when the output register can take a beat.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Register writes; the user must change the config only while the pipeline is empty (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_xy         <= '0;
      row0_zt         <= '0;
      row1_xy         <= '0;
      row1_zt         <= '0;
      row3_xy         <= '0;
      row3_zt         <= '0;
      viewport_size   <= '0;
      viewport_origin <= '0;
    end else if (cfg_valid) begin
      case (wsp_pkg::cfg_reg_t'(cfg_index))
        wsp_pkg::REG_ROW0_XY:   row0_xy         <= cfg_data;
        wsp_pkg::REG_ROW0_ZT:   row0_zt         <= cfg_data;
        wsp_pkg::REG_ROW1_XY:   row1_xy         <= cfg_data;
        wsp_pkg::REG_ROW1_ZT:   row1_zt         <= cfg_data;
        wsp_pkg::REG_ROW3_XY:   row3_xy         <= cfg_data;
        wsp_pkg::REG_ROW3_ZT:   row3_zt         <= cfg_data;
        wsp_pkg::REG_VP_SIZE:   viewport_size   <= cfg_data[31:0];
        wsp_pkg::REG_VP_ORIGIN: viewport_origin <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack matrix rows 0, 1 and 3: low word is the even column.
  always_comb begin
    mat[0][0] = row0_xy[31:0];  mat[0][1] = row0_xy[63:32];
    mat[0][2] = row0_zt[31:0];  mat[0][3] = row0_zt[63:32];
    mat[1][0] = row1_xy[31:0];  mat[1][1] = row1_xy[63:32];
    mat[1][2] = row1_zt[31:0];  mat[1][3] = row1_zt[63:32];
    mat[2][0] = row3_xy[31:0];  mat[2][1] = row3_xy[63:32];
    mat[2][2] = row3_zt[31:0];  mat[2][3] = row3_zt[63:32];
  end

  wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (in_valid),
    .px    (point_x),
    .py    (point_y),
    .pz    (point_z),
    .mat   (mat),
    .vld_o (clip_vld),
    .clip  (clip)
  );

  wsp_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (clip_vld),
    .cx    (clip[0]),
    .cy    (clip[1]),
    .cw    (clip[2]),
    .vld_o (prep_vld),
    .n_x   (n_x),
    .n_y   (n_y),
    .w     (w),
    .flg   (prep_flg),
    .side  (prep_side)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_i  (prep_vld),
    .n_x    (n_x),
    .n_y    (n_y),
    .w      (w),
    .flg    (prep_flg),
    .side   (prep_side),
    .vld_o  (div_vld),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .flg_o  (div_flg),
    .side_o (div_side)
  );

  wsp_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .vld_i     (div_vld),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .flg       (div_flg),
    .side      (div_side),
    .vp_size   (viewport_size),
    .vp_origin (viewport_origin),
    .vld_o     (out_valid),
    .sx        (screen_x),
    .sy        (screen_y),
    .on        (on_screen)
  );

  // A stalled output beat must freeze the input side.
  `WSP_ASSERT(a_backpressure, (out_valid && !out_ready) |-> !in_ready)

endmodule

FILE: rtl/core/wsp_clip.sv
// Clip-space dot products: one multiply stage and one sum stage.
// Depends on wsp_pkg.
module wsp_clip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_i,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  pz,
  input  logic signed [31:0]  mat [3][4],
  output logic                vld_o,
  output logic signed [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] clip [3]
);

  localparam int CW = wsp_pkg::ClipWideBits - FRAC_BITS;

  logic               vld1;
  logic signed [63:0] prod [3][3];
  logic signed [66:0] sum  [3];
  logic signed [66:0] shf  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld1  <= vld_i;
      vld_o <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= mat[r][0] * px;
        prod[r][1] <= mat[r][1] * py;
        prod[r][2] <= mat[r][2] * pz;
      end
      for (int r = 0; r < 3; r++) begin
        clip[r] <= shf[r][CW-1:0] + {{(CW-32){mat[r][3][31]}}, mat[r][3]};
      end
    end
  end

  // Exact floor of the full sum over 2^FRAC_BITS.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {{3{prod[r][0][63]}}, prod[r][0]} + {{3{prod[r][1][63]}}, prod[r][1]}
             + {{3{prod[r][2][63]}}, prod[r][2]};
      shf[r] = sum[r] >>> FRAC_BITS;
    end
  end

endmodule

FILE: rtl/core/wsp_prep.sv
// Near-plane test, behind-camera scaling and divider setup, one stage.
// Depends on wsp_pkg.
module wsp_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_i,
  input  logic signed [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] cx,
  input  logic signed [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] cy,
  input  logic signed [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] cw,
  output logic                vld_o,
  output logic [wsp_pkg::ClipWideBits-1:0]           n_x,
  output logic [wsp_pkg::ClipWideBits-1:0]           n_y,
  output logic [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] w,
  output wsp_pkg::flags_t     flg,
  output wsp_pkg::side_t      side
);

  localparam int CW   = wsp_pkg::ClipWideBits - FRAC_BITS;
  localparam int CMPW = CW + wsp_pkg::RatioCapBits - FRAC_BITS;
  localparam logic signed [CW-1:0] Thresh = CW'((2**FRAC_BITS + 999) / 1000);
  localparam logic signed [CW-1:0] LimHi  = CW'(wsp_pkg::NearLimit);
  localparam logic signed [CW-1:0] LimLo  = CW'(-wsp_pkg::NearLimit);

  logic [CW-1:0]   ax, ay;
  logic [CMPW-1:0] wlim;
  logic            near;

  function automatic logic signed [31:0] scale_near(logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > LimHi) r = wsp_pkg::Sat32Max;
    else if (v < LimLo) r = wsp_pkg::Sat32Min;
    else r = 32'(signed'(v[15:0])) * 32'(wsp_pkg::NearScale);
    return r;
  endfunction

  always_comb begin
    near = cw < Thresh;
    ax   = cx[CW-1] ? CW'(-cx) : cx;
    ay   = cy[CW-1] ? CW'(-cy) : cy;
    wlim = {{(CMPW-CW){1'b0}}, cw} << (wsp_pkg::RatioCapBits - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) vld_o <= 1'b0;
    else if (en) vld_o <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_x        <= {ax, {FRAC_BITS{1'b0}}};
      n_y        <= {ay, {FRAC_BITS{1'b0}}};
      w          <= cw;
      flg.neg_x  <= cx[CW-1];
      flg.neg_y  <= cy[CW-1];
      flg.cap_x  <= {{(CMPW-CW){1'b0}}, ax} >= wlim;
      flg.cap_y  <= {{(CMPW-CW){1'b0}}, ay} >= wlim;
      side.on    <= !near;
      side.off_x <= scale_near(cx);
      side.off_y <= scale_near(cy);
    end
  end

endmodule

FILE: rtl/core/wsp_div.sv
// Pipelined restoring divider: one quotient bit per stage for x/w and y/w.
// Depends on wsp_pkg and world_to_screen_projection_defines.svh.
`include "world_to_screen_projection_defines.svh"
module wsp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_i,
  input  logic [wsp_pkg::ClipWideBits-1:0]           n_x,
  input  logic [wsp_pkg::ClipWideBits-1:0]           n_y,
  input  logic [wsp_pkg::ClipWideBits-FRAC_BITS-1:0] w,
  input  wsp_pkg::flags_t     flg,
  input  wsp_pkg::side_t      side,
  output logic                vld_o,
  output logic [wsp_pkg::RatioCapBits:0] mag_x,
  output logic [wsp_pkg::RatioCapBits:0] mag_y,
  output wsp_pkg::flags_t     flg_o,
  output wsp_pkg::side_t      side_o
);

  localparam int CW  = wsp_pkg::ClipWideBits - FRAC_BITS;
  localparam int NW  = wsp_pkg::ClipWideBits;
  localparam int RW  = CW + 1;
  localparam int NST = wsp_pkg::RatioCapBits;

  typedef struct packed {
    logic [NW-1:0]   n_x;
    logic [NW-1:0]   n_y;
    logic [RW-1:0]   r_x;
    logic [RW-1:0]   r_y;
    logic [NST-1:0]  q_x;
    logic [NST-1:0]  q_y;
    logic [CW-1:0]   w;
    wsp_pkg::flags_t flg;
    wsp_pkg::side_t  side;
  } dst_t;

  logic [NST-1:0] vld;
  dst_t src [NST];
  dst_t nxt [NST];
  dst_t stg [NST];

  function automatic dst_t div_step(dst_t s, logic bx, logic by);
    dst_t       o;
    logic [RW:0] tx, ty, wz;
    o  = s;
    wz = {1'b0, {(RW-CW){1'b0}}, s.w};
    tx = {s.r_x, bx};
    ty = {s.r_y, by};
    if (tx >= wz) tx = tx - wz;
    if (ty >= wz) ty = ty - wz;
    o.r_x = tx[RW-1:0];
    o.r_y = ty[RW-1:0];
    o.q_x = {s.q_x[NST-2:0], {s.r_x, bx} >= wz};
    o.q_y = {s.q_y[NST-2:0], {s.r_y, by} >= wz};
    return o;
  endfunction

  // Seed the partial remainder with the dividend bits above the quotient range.
  assign src[0] = '{
    n_x:  n_x,
    n_y:  n_y,
    r_x:  {{(RW-NW+NST){1'b0}}, n_x[NW-1:NST]},
    r_y:  {{(RW-NW+NST){1'b0}}, n_y[NW-1:NST]},
    q_x:  '0,
    q_y:  '0,
    w:    w,
    flg:  flg,
    side: side
  };

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign src[k] = stg[k-1];
    end
    assign nxt[k] = div_step(src[k], src[k].n_x[NST-1-k], src[k].n_y[NST-1-k]);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], vld_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) stg[k] <= nxt[k];
    end
  end

  assign vld_o  = vld[NST-1];
  assign flg_o  = stg[NST-1].flg;
  assign side_o = stg[NST-1].side;
  assign mag_x  = stg[NST-1].flg.cap_x ? {1'b1, {NST{1'b0}}} : {1'b0, stg[NST-1].q_x};
  assign mag_y  = stg[NST-1].flg.cap_y ? {1'b1, {NST{1'b0}}} : {1'b0, stg[NST-1].q_y};

  `WSP_ASSERT_NEXT(a_div_hold, !en, $stable(vld))
  `WSP_ASSERT_NEXT(a_div_shift, en, vld[NST-1:1] == $past(vld[NST-2:0]))

endmodule

FILE: rtl/core/wsp_view.sv
// Viewport mapping: scale multiply stage, then offset, saturate and select.
// Depends on wsp_pkg.
module wsp_view #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_i,
  input  logic [wsp_pkg::RatioCapBits:0] mag_x,
  input  logic [wsp_pkg::RatioCapBits:0] mag_y,
  input  wsp_pkg::flags_t     flg,
  input  wsp_pkg::side_t      side,
  input  logic [31:0]         vp_size,
  input  logic [31:0]         vp_origin,
  output logic                vld_o,
  output logic signed [31:0]  sx,
  output logic signed [31:0]  sy,
  output logic                on
);

  localparam int MW = wsp_pkg::RatioCapBits + 1;
  localparam int PW = MW + 16;
  localparam int SW = PW + 2;

  logic                 vld1;
  logic [PW-1:0]        p_x, p_y;
  wsp_pkg::flags_t      flg1;
  wsp_pkg::side_t       side1;
  logic signed [SW-1:0] t_x, t_y, s_x, s_y;

  function automatic logic signed [31:0] sat32(logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > SW'(wsp_pkg::Sat32Max)) r = wsp_pkg::Sat32Max;
    else if (v < SW'(wsp_pkg::Sat32Min)) r = wsp_pkg::Sat32Min;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld1  <= vld_i;
      vld_o <= vld1;
    end
  end

  // Halve the magnitude, then apply the sign: truncation toward zero.
  always_comb begin
    t_x = {{3{1'b0}}, p_x[PW-1:1]};
    t_y = {{3{1'b0}}, p_y[PW-1:1]};
    if (flg1.neg_x) t_x = -t_x;
    if (flg1.neg_y) t_y = -t_y;
    s_x = (SW'(vp_size[15:0]) << (FRAC_BITS - 1)) + t_x
        + ({{(SW-16){vp_origin[15]}}, vp_origin[15:0]} << FRAC_BITS);
    s_y = (SW'(vp_size[31:16]) << (FRAC_BITS - 1)) - t_y
        + ({{(SW-16){vp_origin[31]}}, vp_origin[31:16]} << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x   <= PW'(mag_x) * PW'(vp_size[15:0]);
      p_y   <= PW'(mag_y) * PW'(vp_size[31:16]);
      flg1  <= flg;
      side1 <= side;
      sx    <= side1.on ? sat32(s_x) : side1.off_x;
      sy    <= side1.on ? sat32(s_y) : side1.off_y;
      on    <= side1.on;
    end
  end

endmodule

FILE: test/world_to_screen_projection_test.sv
// Self-checking testbench for the world-to-screen projection pipeline.
// Depends on wsp_pkg and the world_to_screen_projection RTL; nothing else.
module world_to_screen_projection_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int PIPE_LATENCY = 51;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               on;
  } screen_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic on_screen;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  world_to_screen_projection #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_x(screen_x), .screen_y(screen_y), .on_screen(on_screen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the matrix and viewport registers.
  logic [63:0] shadow_regs [8];
  screen_pt_t pending_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  // Signed matrix entry: row slot 0,1,2 stands for matrix rows 0,1,3.
  function automatic longint mat_entry(int slot, int col);
    logic [63:0] r;
    r = shadow_regs[slot * 2 + col / 2];
    return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  // Exact floor of the full-precision dot product divided by 2^F.
  function automatic longint clip_row(int slot, longint px, longint py, longint pz);
    logic signed [127:0] acc;
    acc = (128'(signed'(mat_entry(slot, 3))) <<< FRAC_BITS)
        + 128'(signed'(mat_entry(slot, 0) * px))
        + 128'(signed'(mat_entry(slot, 1) * py))
        + 128'(signed'(mat_entry(slot, 2) * pz));
    return longint'(acc >>> FRAC_BITS);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(wsp_pkg::Sat32Max)) return longint'(wsp_pkg::Sat32Max);
    if (v < longint'(wsp_pkg::Sat32Min)) return longint'(wsp_pkg::Sat32Min);
    return v;
  endfunction

  // Truncated quotient x/w in Q.F, magnitude capped at 2^46; w > 0.
  function automatic longint clip_ratio(longint x, longint w);
    logic [127:0] ax;
    logic [127:0] q;
    ax = (x < 0) ? 128'(-x) : 128'(x);
    if (ax / 128'(w) >= (128'(1) << (wsp_pkg::RatioCapBits - FRAC_BITS)))
      q = 128'(1) << wsp_pkg::RatioCapBits;
    else q = (ax << FRAC_BITS) / 128'(w);
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint near_scale(longint v);
    if (v > wsp_pkg::NearLimit) return longint'(wsp_pkg::Sat32Max);
    if (v < -wsp_pkg::NearLimit) return longint'(wsp_pkg::Sat32Min);
    return v * wsp_pkg::NearScale;
  endfunction

  function automatic screen_pt_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                               logic signed [31:0] pz);
    screen_pt_t r;
    longint cx, cy, cw, wd, ht, ox, oy, tx, ty;
    longint near_w;
    near_w = ((longint'(1) << FRAC_BITS) + 999) / 1000;
    cx = clip_row(0, px, py, pz);
    cy = clip_row(1, px, py, pz);
    cw = clip_row(2, px, py, pz);
    if (cw < near_w) begin
      r.sx = 32'(near_scale(cx));
      r.sy = 32'(near_scale(cy));
      r.on = 1'b0;
    end else begin
      wd = longint'(shadow_regs[wsp_pkg::REG_VP_SIZE][15:0]);
      ht = longint'(shadow_regs[wsp_pkg::REG_VP_SIZE][31:16]);
      ox = longint'($signed(shadow_regs[wsp_pkg::REG_VP_ORIGIN][15:0]));
      oy = longint'($signed(shadow_regs[wsp_pkg::REG_VP_ORIGIN][31:16]));
      tx = clip_ratio(cx, cw) * wd / 2;
      ty = clip_ratio(cy, cw) * ht / 2;
      r.sx = 32'(clamp32(wd * (longint'(1) << (FRAC_BITS - 1)) + tx + (ox <<< FRAC_BITS)));
      r.sy = 32'(clamp32(ht * (longint'(1) << (FRAC_BITS - 1)) - ty + (oy <<< FRAC_BITS)));
      r.on = 1'b1;
    end
    return r;
  endfunction

  // Send one point beat; predict at acceptance with the current registers.
  // Valid stays up after the beat so points can follow back to back.
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_points.push_back(project_point(px, py, pz));
  endtask

  // Registers change only with the pipeline drained.
  task automatic write_reg(wsp_pkg::cfg_reg_t idx, logic [63:0] val);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_regs[idx] = (idx >= wsp_pkg::REG_VP_SIZE) ? {32'd0, val[31:0]} : val;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] q_pair(real lo, real hi);
    return {32'($rtoi(hi * 65536.0)), 32'($rtoi(lo * 65536.0))};
  endfunction

  // A plain camera: x and y pass through, w = z, viewport size and origin from the arguments.
  task automatic load_camera(int w, int h, int ox, int oy);
    write_reg(wsp_pkg::REG_ROW0_XY, q_pair(1.0, 0.0));
    write_reg(wsp_pkg::REG_ROW0_ZT, q_pair(0.0, 0.0));
    write_reg(wsp_pkg::REG_ROW1_XY, q_pair(0.0, 1.0));
    write_reg(wsp_pkg::REG_ROW1_ZT, q_pair(0.0, 0.0));
    write_reg(wsp_pkg::REG_ROW3_XY, q_pair(0.0, 0.0));
    write_reg(wsp_pkg::REG_ROW3_ZT, q_pair(1.0, 0.0));
    write_reg(wsp_pkg::REG_VP_SIZE, {32'd0, 16'(h), 16'(w)});
    write_reg(wsp_pkg::REG_VP_ORIGIN, {32'd0, 16'(oy), 16'(ox)});
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3, 0))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(65536 * 40, 0)) - 32'(65536 * 20));
      2: return $signed($urandom_range(1, 0) ? wsp_pkg::Sat32Max : wsp_pkg::Sat32Min);
      default: return $signed(32'($urandom_range(4000, 0)) - 32'd2000);
    endcase
  endfunction

  // Directed: extremes, near-plane boundary, saturation, zero viewport.
  task automatic test_directed();
    load_camera(640, 480, 0, 0);
    send_point(0, 0, 32'sh0001_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
    send_point(0, 0, 65);        // just under the 0.001 near limit
    send_point(0, 0, 66);        // exactly at the near limit
    send_point(32'sh0000_5000, -32'sh0000_5000, 0);
    send_point(wsp_pkg::Sat32Max, wsp_pkg::Sat32Min, 66);
    send_point(wsp_pkg::Sat32Min, wsp_pkg::Sat32Max, wsp_pkg::Sat32Max);
    send_point(wsp_pkg::Sat32Max, wsp_pkg::Sat32Max, wsp_pkg::Sat32Min);
    send_point(21474, -21474, -1);
    send_point(21475, -21475, -1);
    send_point(-1, -1, -1);
    send_point(wsp_pkg::Sat32Max, wsp_pkg::Sat32Max, wsp_pkg::Sat32Max);
    load_camera(65535, 65535, -32768, 32767);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
    send_point(wsp_pkg::Sat32Min, wsp_pkg::Sat32Max, 66);
    send_point(0, 0, 32'sh0001_0000);
    load_camera(0, 0, 32767, -32768);
    send_point(32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000);
    send_point(wsp_pkg::Sat32Max, wsp_pkg::Sat32Min, -32'sh0001_0000);
    // Full-range matrix entries.
    write_reg(wsp_pkg::REG_ROW0_XY, 64'h8000_0000_7fff_ffff);
    write_reg(wsp_pkg::REG_ROW0_ZT, 64'h7fff_ffff_8000_0000);
    write_reg(wsp_pkg::REG_ROW1_XY, 64'hffff_ffff_ffff_ffff);
    write_reg(wsp_pkg::REG_ROW3_XY, 64'h0000_0001_8000_0000);
    write_reg(wsp_pkg::REG_ROW3_ZT, 64'h7fff_ffff_7fff_ffff);
    write_reg(wsp_pkg::REG_VP_SIZE, 64'hffff_ffff_ffff_ffff);
    send_point(wsp_pkg::Sat32Max, wsp_pkg::Sat32Max, wsp_pkg::Sat32Max);
    send_point(wsp_pkg::Sat32Min, wsp_pkg::Sat32Min, wsp_pkg::Sat32Min);
    send_point(0, 0, 0);
  endtask

  task automatic random_matrix();
    int k;
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(3, 0) == 0)
        write_reg(wsp_pkg::cfg_reg_t'(k), {$urandom(), $urandom()});
      else write_reg(wsp_pkg::cfg_reg_t'(k),
                     {32'($urandom_range(65536 * 4, 0)) - 32'(65536 * 2),
                      32'($urandom_range(65536 * 4, 0)) - 32'(65536 * 2)});
    end
    write_reg(wsp_pkg::REG_VP_SIZE, {$urandom(), $urandom()});
    write_reg(wsp_pkg::REG_VP_ORIGIN, {$urandom(), $urandom()});
  endtask

  // Mostly a sane camera with random points, some fully random matrices.
  task automatic test_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        if ($urandom_range(2, 0) == 0) random_matrix();
        else load_camera($urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0));
      end
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Hold the screen side off for a long stretch so the pipeline backs up.
  task automatic test_backpressure();
    int n;
    hold_off = 1'b1;
    for (n = 0; n < 120; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    hold_off = 1'b0;
  endtask

  // Receiver: random stalls, plus the long hold-off counted in cycles.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off && idle_cycles < 300) begin
      out_ready <= 1'b0;
      idle_cycles <= idle_cycles + 1;
    end else out_ready <= !($urandom_range(99, 0) < recv_idle_pct);
  end

  // Compare each screen beat with the oldest prediction.
  always @(posedge clk) begin
    screen_pt_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected screen beat x=%0d y=%0d on=%0b",
                 $time, screen_x, screen_y, on_screen);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (screen_x !== exp_pt.sx) begin
          $display("%0t: screen_x expected %0d got %0d", $time, exp_pt.sx, screen_x);
          errors++;
        end
        if (screen_y !== exp_pt.sy) begin
          $display("%0t: screen_y expected %0d got %0d", $time, exp_pt.sy, screen_y);
          errors++;
        end
        if (on_screen !== exp_pt.on) begin
          $display("%0t: on_screen expected %0b got %0b", $time, exp_pt.on, on_screen);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < 8; k++) shadow_regs[k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 66;
    test_directed();
    test_random(450);
    test_backpressure();
    send_idle_pct = 66;
    recv_idle_pct = 9;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(450);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
